/* hdl/flvd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_pkg - shared types and constants of the flv to annex b demux
// Command format passed from the parser to the output side, error codes and
// the fixed byte values of the container format.
// ----------------------------------------------------------------------------
package flvd_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd60000;

   // file signature
   localparam logic [7:0] SIG_F = 8'h46;
   localparam logic [7:0] SIG_L = 8'h4C;
   localparam logic [7:0] SIG_V = 8'h56;

   // tag types
   localparam logic [7:0] TAG_AUDIO  = 8'd8;
   localparam logic [7:0] TAG_VIDEO  = 8'd9;
   localparam logic [7:0] TAG_SCRIPT = 8'd18;

   localparam logic [3:0] CODEC_AVC = 4'd7;

   // avc packet types
   localparam logic [7:0] AVC_SEQ_HDR = 8'd0;
   localparam logic [7:0] AVC_NALU    = 8'd1;
   localparam logic [7:0] AVC_EOS     = 8'd2;

   localparam logic [4:0] SPS_COUNT_MASK = 5'h1f;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE   = 3'd1;
   localparam logic [2:0] ERR_TAG_TYPE    = 3'd2;
   localparam logic [2:0] ERR_CODEC       = 3'd3;
   localparam logic [2:0] ERR_PACKET_TYPE = 3'd4;
   localparam logic [2:0] ERR_SPS_COUNT   = 3'd5;
   localparam logic [2:0] ERR_PPS_COUNT   = 3'd6;
   localparam logic [2:0] ERR_PAYLOAD     = 3'd7;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_START_CODE,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [2:0]   code;
   } cmd_type;

endpackage

/* hdl/flv_video_to_annexb_demux.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_video_to_annexb_demux - flv container to h.264 annex b byte stream
// Takes an flv file one byte a word and emits the avc elementary stream.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries the file bytes; a word moves when req_valid is high
//  and req_stall is low. rsp_ channel carries annex b bytes or one error
//  word; rsp_last marks the final word caused by an input byte.
//  csr_ channel writes max_payload; csr_ready is always high. Write it only
//  while no words are in flight.
//  Throughput: one input byte per cycle while req_stall is low. Each byte yields
//  at most one word, except the byte that ends an sps or pps length, which
//  yields the four start-code words; the expander takes no new command while
//  it sends them, and the queue soaks up the commands that arrive meanwhile.
//  A result word is registered twice on its way out after its input byte is
//  taken: once in the queue and once in the expander.
//  A four-entry command queue sits between parser and expander; req_stall
//  rises only when that queue is full, so an output stall backs up through
//  the queue before the input is held.
//  Reset clears the parser to the file signature, empties the queue and
//  sets max_payload to 60000. After an error word no output appears until
//  reset, while input bytes keep being taken.
// ----------------------------------------------------------------------------
module flv_video_to_annexb_demux #(
   parameter int unsigned QUEUE_DEPTH = flvd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_error,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_max_payload
);

   logic              byte_accept;
   logic              cmd_push;
   flvd_pkg::cmd_type cmd;
   logic              cmd_pop;
   logic              cmd_avail;
   logic              queue_full;
   flvd_pkg::cmd_type cmd_head;

   assign csr_ready   = 1'b1;
   assign req_stall   = queue_full;
   assign byte_accept = req_valid && !queue_full;

   flvd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .in_byte     (req_in_byte),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_max_payload),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   flvd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd),
      .pop       (cmd_pop),
      .not_empty (cmd_avail),
      .full      (queue_full),
      .head      (cmd_head)
   );

   flvd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_avail      (cmd_avail),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_error   (rsp_is_error),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

/* hdl/flvd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_front - container parser
// Walks the file header, tag headers and video tag bodies one byte per word
// and issues output commands into the command queue.
// ----------------------------------------------------------------------------
module flvd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_accept,
   input  logic [7:0]        in_byte,
   input  logic              csr_write,
   input  logic [23:0]       csr_data,
   output logic              cmd_push,
   output flvd_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      PH_SIG,
      PH_PREV,
      PH_THDR,
      PH_SKIP,
      PH_VFLAGS,
      PH_PKTTYPE,
      PH_CTSF,
      PH_FRAME,
      PH_CFGHDR,
      PH_NSPS,
      PH_SPSLEN,
      PH_SPS,
      PH_NPPS,
      PH_PPSLEN,
      PH_PPS
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [23:0] body_ff, body_in;
   logic [15:0] psl_ff, psl_in;
   logic        is_video_ff, is_video_in;
   logic        failed_ff, failed_in;
   logic [23:0] max_payload_ff;

   logic        in_body;
   logic        err;
   logic [23:0] body_dec;
   logic [23:0] rem;
   logic [23:0] payload;
   logic [15:0] psl_new;
   logic [15:0] count_inc;

   assign in_body = (phase_ff != PH_SIG) && (phase_ff != PH_PREV) && (phase_ff != PH_THDR);
   assign body_dec  = body_ff - 24'd1;
   assign rem       = body_ff - 24'd1;
   assign payload   = (rem >= 24'd3) ? (rem - 24'd3) : 24'd0;
   assign psl_new   = {psl_ff[15:8], in_byte};
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      body_in     = body_ff;
      psl_in      = psl_ff;
      is_video_in = is_video_ff;
      failed_in   = failed_ff;
      err         = 1'b0;
      cmd_push    = 1'b0;
      cmd.kind    = flvd_pkg::CMD_BYTE;
      cmd.data    = in_byte;
      cmd.code    = flvd_pkg::ERR_NONE;

      if (byte_accept && !failed_ff) begin
         case (phase_ff)
            PH_SIG: begin
               if ((count_ff == 16'd0 && in_byte != flvd_pkg::SIG_F) ||
                   (count_ff == 16'd1 && in_byte != flvd_pkg::SIG_L) ||
                   (count_ff == 16'd2 && in_byte != flvd_pkg::SIG_V)) begin
                  err      = 1'b1;
                  cmd.code = flvd_pkg::ERR_SIGNATURE;
               end else if (count_ff >= 16'd8) begin
                  phase_in = PH_PREV;
                  count_in = 16'd0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_PREV: begin
               if (count_ff >= 16'd3) begin
                  phase_in = PH_THDR;
                  count_in = 16'd0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_THDR: begin
               if (count_ff == 16'd0) begin
                  if (in_byte != flvd_pkg::TAG_AUDIO && in_byte != flvd_pkg::TAG_VIDEO &&
                      in_byte != flvd_pkg::TAG_SCRIPT) begin
                     err      = 1'b1;
                     cmd.code = flvd_pkg::ERR_TAG_TYPE;
                  end
                  is_video_in = (in_byte == flvd_pkg::TAG_VIDEO);
                  body_in     = 24'd0;
               end else if (count_ff <= 16'd3) begin
                  body_in = {body_ff[15:0], in_byte};
               end
               if (count_ff >= 16'd10) begin
                  count_in = 16'd0;
                  if (body_ff == 24'd0) begin
                     phase_in = PH_PREV;
                  end else if (is_video_ff) begin
                     phase_in = PH_VFLAGS;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  count_in = count_inc;
               end
            end
            PH_SKIP: begin
            end
            PH_VFLAGS: begin
               if (in_byte[3:0] != flvd_pkg::CODEC_AVC) begin
                  err      = 1'b1;
                  cmd.code = flvd_pkg::ERR_CODEC;
               end else begin
                  phase_in = PH_PKTTYPE;
                  count_in = 16'd0;
               end
            end
            PH_PKTTYPE: begin
               count_in = 16'd0;
               if (in_byte == flvd_pkg::AVC_SEQ_HDR) begin
                  phase_in = PH_CFGHDR;
               end else if (in_byte == flvd_pkg::AVC_NALU) begin
                  if (payload >= max_payload_ff) begin
                     err      = 1'b1;
                     cmd.code = flvd_pkg::ERR_PAYLOAD;
                  end else begin
                     phase_in = PH_CTSF;
                  end
               end else if (in_byte == flvd_pkg::AVC_EOS) begin
                  phase_in = PH_SKIP;
               end else begin
                  err      = 1'b1;
                  cmd.code = flvd_pkg::ERR_PACKET_TYPE;
               end
            end
            PH_CTSF: begin
               if (count_ff >= 16'd2) begin
                  phase_in = PH_FRAME;
                  count_in = 16'd0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_FRAME: begin
               cmd_push = 1'b1;
               // first four payload bytes turn into a start code
               if (count_ff < 16'd4) begin
                  cmd.data = (count_ff == 16'd3) ? 8'h01 : 8'h00;
                  count_in = count_inc;
               end
            end
            PH_CFGHDR: begin
               if (count_ff >= 16'd7) begin
                  phase_in = PH_NSPS;
                  count_in = 16'd0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_NSPS: begin
               if ((in_byte[4:0] & flvd_pkg::SPS_COUNT_MASK) != 5'd1 || in_byte[7:5] != 3'd0) begin
                  if ((in_byte[4:0] & flvd_pkg::SPS_COUNT_MASK) != 5'd1) begin
                     err      = 1'b1;
                     cmd.code = flvd_pkg::ERR_SPS_COUNT;
                  end
               end
               if (!err) begin
                  phase_in = PH_SPSLEN;
                  count_in = 16'd0;
               end
            end
            PH_NPPS: begin
               if (in_byte != 8'd1) begin
                  err      = 1'b1;
                  cmd.code = flvd_pkg::ERR_PPS_COUNT;
               end else begin
                  phase_in = PH_PPSLEN;
                  count_in = 16'd0;
               end
            end
            PH_SPSLEN, PH_PPSLEN: begin
               if (count_ff == 16'd0) begin
                  psl_in   = {in_byte, 8'h00};
                  count_in = 16'd1;
               end else begin
                  psl_in   = psl_new;
                  cmd_push = 1'b1;
                  cmd.kind = flvd_pkg::CMD_START_CODE;
                  count_in = 16'd0;
                  if (psl_new == 16'd0) begin
                     phase_in = (phase_ff == PH_SPSLEN) ? PH_NPPS : PH_SKIP;
                  end else begin
                     phase_in = (phase_ff == PH_SPSLEN) ? PH_SPS : PH_PPS;
                  end
               end
            end
            PH_SPS, PH_PPS: begin
               cmd_push = 1'b1;
               count_in = count_inc;
               if (count_inc >= psl_ff) begin
                  phase_in = (phase_ff == PH_SPS) ? PH_NPPS : PH_SKIP;
                  count_in = 16'd0;
               end
            end
            default: begin
               phase_in = PH_SKIP;
               count_in = 16'd0;
            end
         endcase

         if (err) begin
            cmd_push  = 1'b1;
            cmd.kind  = flvd_pkg::CMD_ERROR;
            cmd.data  = 8'h00;
            failed_in = 1'b1;
         end else if (in_body) begin
            // end of the tag body wins over the parse phase unless the byte raised an error
            body_in = body_dec;
            if (body_dec == 24'd0) begin
               phase_in = PH_PREV;
               count_in = 16'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIG;
         count_ff       <= 16'd0;
         body_ff        <= 24'd0;
         psl_ff         <= 16'd0;
         is_video_ff    <= 1'b0;
         failed_ff      <= 1'b0;
         max_payload_ff <= flvd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         body_ff     <= body_in;
         psl_ff      <= psl_in;
         is_video_ff <= is_video_in;
         failed_ff   <= failed_in;
         if (csr_write) begin
            max_payload_ff <= csr_data;
         end
      end
   end

   // once failed, the parser stays failed until reset
   assert property (@(posedge clock) disable iff (reset) failed_ff |=> failed_ff)
      else $error("flvd_front: sticky error cleared");

   // nothing leaves the parser after an error word
   assert property (@(posedge clock) disable iff (reset) failed_ff |-> !cmd_push)
      else $error("flvd_front: command after error");

endmodule

/* hdl/flvd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_queue - command queue
// Small register fifo that decouples the parser from the output expander.
// ----------------------------------------------------------------------------
module flvd_queue #(
   parameter int unsigned DEPTH = flvd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  flvd_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output flvd_pkg::cmd_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   flvd_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("flvd_queue: occupancy overflow");

   // the parser is held off while full, so no command is ever dropped
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("flvd_queue: push into full queue");

endmodule

/* hdl/flvd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_back - output expander
// Turns queued commands into result words; a start code takes four words.
// ----------------------------------------------------------------------------
module flvd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_avail,
   input  flvd_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_error,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last
);

   logic              valid_ff, valid_in;
   flvd_pkg::cmd_type cur_ff, cur_in;
   logic [1:0]        idx_ff, idx_in;

   logic is_start;
   logic mid_start;
   logic load;

   assign is_start  = (cur_ff.kind == flvd_pkg::CMD_START_CODE);
   assign mid_start = is_start && (idx_ff != 2'd3);
   assign load      = !valid_ff || (!rsp_stall && !mid_start);
   assign cmd_pop   = load && cmd_avail;

   always_comb begin
      valid_in = valid_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = cmd_avail;
         cur_in   = cmd_head;
         idx_in   = 2'd0;
      end else if (!rsp_stall) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      rsp_out_byte = cur_ff.data;
      case (cur_ff.kind)
         flvd_pkg::CMD_START_CODE: rsp_out_byte = (idx_ff == 2'd3) ? 8'h01 : 8'h00;
         flvd_pkg::CMD_ERROR:      rsp_out_byte = 8'h00;
         default:                  rsp_out_byte = cur_ff.data;
      endcase
   end

   assign rsp_valid      = valid_ff;
   assign rsp_is_error   = (cur_ff.kind == flvd_pkg::CMD_ERROR);
   assign rsp_error_code = rsp_is_error ? cur_ff.code : flvd_pkg::ERR_NONE;
   assign rsp_last       = !mid_start;

endmodule
